// ===== hdl/bcu_pkg.sv =====
package bcu_pkg;

   // width of one input field
   localparam int FIELD_W = 31;
   // width of the coefficient port
   localparam int COEF_W = 32;
   // width at which the running value saturates, 8 .. 32
   localparam int RES_W = 32;
   // product of the running value and (k - i); dividend and quotient
   localparam int QUO_W = RES_W + FIELD_W;
   // division step counter
   localparam int CNT_W = $clog2(QUO_W);
   // index of the last division step
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);
   // saturated coefficient, all ones of RES_W bits
   localparam logic [COEF_W-1:0] SAT_VALUE = COEF_W'((64'd1 << RES_W) - 64'd1);

   // commands from controller to datapath
   typedef struct packed {
      logic load;       // latch k and min(n, k - n), start a new pair
      logic mul;        // product of running value and (k - i)
      logic div_step;   // one restoring division step
      logic update;     // take quotient as new running value, advance i
      logic emit;       // load result register
   } bcu_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic gt;         // n greater than k
      logic ovf;        // running value passed RES_W bits
      logic loop_done;  // i reached min(n, k - n)
      logic div_last;   // last division step this cycle
      logic out_busy;   // result register still held by the receiver
   } bcu_sts_type;

endpackage

// ===== hdl/bcu_ctrl.sv =====
module bcu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bcu_pkg::bcu_sts_type sts,
   output bcu_pkg::bcu_cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOP   = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_UPDATE = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (sts.gt || sts.ovf || sts.loop_done) begin
               state_in = S_FINISH;
            end else begin
               cmd.mul  = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_LOOP;
         end
         S_FINISH: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/bcu_dp.sv =====
module bcu_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  bcu_pkg::bcu_cmd_type               cmd,
   output bcu_pkg::bcu_sts_type               sts,
   input  logic [bcu_pkg::FIELD_W-1:0]        req_total_items,
   input  logic [bcu_pkg::FIELD_W-1:0]        req_chosen_items,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [bcu_pkg::COEF_W-1:0]         rsp_coefficient,
   output logic                               rsp_overflow
);

   logic [bcu_pkg::FIELD_W-1:0] k_ff, k_in;
   logic [bcu_pkg::FIELD_W-1:0] m_ff, m_in;
   logic [bcu_pkg::FIELD_W-1:0] i_ff, i_in;
   logic [bcu_pkg::FIELD_W-1:0] divisor_ff, divisor_in;
   logic [bcu_pkg::RES_W-1:0]   r_ff, r_in;
   logic [bcu_pkg::QUO_W-1:0]   quo_ff, quo_in;
   logic [bcu_pkg::FIELD_W-1:0] rem_ff, rem_in;
   logic [bcu_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        gt_ff, gt_in;
   logic                        ovf_ff, ovf_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bcu_pkg::COEF_W-1:0]  coef_ff, coef_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;

   logic [bcu_pkg::FIELD_W-1:0] rest;
   logic [bcu_pkg::FIELD_W-1:0] factor;
   logic [bcu_pkg::QUO_W-1:0]   product;
   logic [bcu_pkg::FIELD_W:0]   rem_shift;
   logic                        rem_ge;
   logic                        quo_wide;

   // k - n, only used when n does not exceed k
   assign rest    = req_total_items - req_chosen_items;
   assign factor  = k_ff - i_ff;
   assign product = bcu_pkg::QUO_W'(r_ff) * bcu_pkg::QUO_W'(factor);

   // restoring division, one quotient bit per step
   assign rem_shift = {rem_ff, quo_ff[bcu_pkg::QUO_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, divisor_ff});
   assign quo_wide  = |quo_ff[bcu_pkg::QUO_W-1:bcu_pkg::RES_W];

   always_comb begin
      k_in       = k_ff;
      m_in       = m_ff;
      i_in       = i_ff;
      divisor_in = divisor_ff;
      r_in       = r_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      gt_in      = gt_ff;
      ovf_in     = ovf_ff;
      coef_in    = coef_ff;
      rsp_ovf_in = rsp_ovf_ff;

      if (cmd.load) begin
         k_in   = req_total_items;
         gt_in  = (req_chosen_items > req_total_items);
         m_in   = (req_chosen_items < rest) ? req_chosen_items : rest;
         i_in   = '0;
         r_in   = bcu_pkg::RES_W'(1);
         ovf_in = 1'b0;
      end

      if (cmd.mul) begin
         quo_in     = product;
         rem_in     = '0;
         cnt_in     = '0;
         divisor_in = i_ff + bcu_pkg::FIELD_W'(1);
      end

      if (cmd.div_step) begin
         quo_in = {quo_ff[bcu_pkg::QUO_W-2:0], rem_ge};
         rem_in = rem_ge ? bcu_pkg::FIELD_W'(rem_shift - {1'b0, divisor_ff})
                         : bcu_pkg::FIELD_W'(rem_shift);
         cnt_in = cnt_ff + bcu_pkg::CNT_W'(1);
      end

      if (cmd.update) begin
         r_in   = quo_ff[bcu_pkg::RES_W-1:0];
         ovf_in = quo_wide;
         i_in   = i_ff + bcu_pkg::FIELD_W'(1);
      end

      if (cmd.emit) begin
         rsp_ovf_in = ovf_ff & ~gt_ff;
         if (gt_ff) begin
            coef_in = '0;
         end else if (ovf_ff) begin
            coef_in = bcu_pkg::SAT_VALUE;
         end else begin
            coef_in = bcu_pkg::COEF_W'(r_ff);
         end
      end
   end

   // result register is freed when the receiver takes the beat
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         gt_ff        <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         gt_ff        <= gt_in;
         ovf_ff       <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      m_ff       <= m_in;
      i_ff       <= i_in;
      divisor_ff <= divisor_in;
      r_ff       <= r_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      coef_ff    <= coef_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign sts.gt        = gt_ff;
   assign sts.ovf       = ovf_ff;
   assign sts.loop_done = (i_ff == m_ff);
   assign sts.div_last  = (cnt_ff == bcu_pkg::DIV_LAST);
   assign sts.out_busy  = rsp_valid_ff & rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coefficient = coef_ff;
   assign rsp_overflow    = rsp_ovf_ff;

   // remainder of the division always stays below the divisor
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> (rem_ff < divisor_ff))
      else $error("division remainder reached divisor");

   // an overflow sticks until the next pair is loaded
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      (ovf_ff && !cmd.load) |=> ovf_ff)
      else $error("overflow flag dropped within a pair");

   // n > k never enters the multiply loop
   a_gt_no_mul: assert property (@(posedge clock) disable iff (reset)
      gt_ff |-> !cmd.mul)
      else $error("multiply issued for n greater than k");

   // an overflowed result is always the saturated value
   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |-> (coef_ff == bcu_pkg::SAT_VALUE))
      else $error("overflow result not saturated");

endmodule

// ===== hdl/binomial_coefficient_unit_top.sv =====
// load, then finish directly if n > k or min(n, k-n) is 0, else after the loop passes
// one pass = a multiply, 63 restoring division steps and an update
// passes: min(n, k-n), cut short at the first pass that overflows (17 at most)
// throughput: one pair at a time, next pair accepted once the result sits in the output
// reset: synchronous, active high; clears controller state, output valid, gt and overflow flags
module binomial_coefficient_unit_top (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [bcu_pkg::FIELD_W-1:0] req_total_items,
   input  logic [bcu_pkg::FIELD_W-1:0] req_chosen_items,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bcu_pkg::COEF_W-1:0]  rsp_coefficient,
   output logic                        rsp_overflow
);

   // command and status between the sequencer and the arithmetic
   bcu_pkg::bcu_cmd_type cmd;
   bcu_pkg::bcu_sts_type sts;

   // sequencer: load, loop over i, one division per pass, hand result to output
   bcu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: running value times (k - i), exact divide by (i + 1),
   // saturation check and output register that parts the two channels
   bcu_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_total_items  (req_total_items),
      .req_chosen_items (req_chosen_items),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_coefficient  (rsp_coefficient),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

// ===== test/binomial_coefficient_unit_top_test.sv =====
`timescale 1ns / 1ps

module binomial_coefficient_unit_top_test;

   // one result beat as the checker sees it
   typedef struct packed {
      logic [bcu_pkg::COEF_W-1:0] coefficient;
      logic                       overflow;
   } coef_result_type;

   // one row of the directed table
   typedef struct packed {
      logic [bcu_pkg::FIELD_W-1:0] total;
      logic [bcu_pkg::FIELD_W-1:0] chosen;
      logic                        typed;    // expected result written in the row
      coef_result_type             want;
   } pair_row_type;

   localparam logic [bcu_pkg::FIELD_W-1:0] K_MAX = {bcu_pkg::FIELD_W{1'b1}};
   localparam coef_result_type NO_RES   = '0;
   localparam coef_result_type ZERO_RES = '{bcu_pkg::COEF_W'(0), 1'b0};
   localparam coef_result_type ONE_RES  = '{bcu_pkg::COEF_W'(1), 1'b0};
   localparam coef_result_type KMAX_RES = '{bcu_pkg::COEF_W'(K_MAX), 1'b0};
   localparam coef_result_type SAT_RES  = '{bcu_pkg::SAT_VALUE, 1'b1};

   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_PAIRS = 240;
   localparam int BURST_PAIRS  = 6;
   // long enough for the next burst pair to finish behind a held result
   localparam int HOLD_CYCLES  = 1500;
   // one pair can run 17 loop passes with no beat on either side
   localparam int QUIET_LIMIT  = 20000;
   localparam int TAIL_CYCLES  = 100;

   logic                         clock;
   logic                         reset            = 1'b1;
   logic                         req_valid        = 1'b0;
   logic                         req_stall;
   logic [bcu_pkg::FIELD_W-1:0]  req_total_items  = '0;
   logic [bcu_pkg::FIELD_W-1:0]  req_chosen_items = '0;
   logic                         rsp_valid;
   logic                         rsp_stall        = 1'b0;
   logic [bcu_pkg::COEF_W-1:0]   rsp_coefficient;
   logic                         rsp_overflow;

   // expected coefficients, oldest first
   coef_result_type pending_coefs[$];
   int mismatch_count = 0;
   int quiet_cycles   = 0;

   // idle rates in percent, changed per phase by the stimulus process
   int send_idle_pct = 15;
   int recv_idle_pct = 65;

   // the stimulus bumps this to ask the response side for one long hold
   int hold_requests = 0;

   // directed pairs: extremes, n > k, empty and full choice, overflow edges
   pair_row_type directed_rows [26] = '{
      '{31'd0,          31'd0,          1'b1, ONE_RES},
      '{31'd5,          31'd0,          1'b1, ONE_RES},
      '{31'd5,          31'd5,          1'b1, ONE_RES},
      '{31'd3,          31'd5,          1'b1, ZERO_RES},
      '{31'd0,          K_MAX,          1'b1, ZERO_RES},
      '{K_MAX - 31'd1,  K_MAX,          1'b1, ZERO_RES},
      '{31'h2AAA_AAAA,  31'h5555_5555,  1'b1, ZERO_RES},
      '{K_MAX,          K_MAX,          1'b1, ONE_RES},
      '{K_MAX,          31'd0,          1'b1, ONE_RES},
      '{31'd1,          31'd1,          1'b1, ONE_RES},
      '{31'd0,          31'd1,          1'b1, ZERO_RES},
      '{K_MAX,          31'd1,          1'b1, KMAX_RES},
      '{K_MAX,          K_MAX - 31'd1,  1'b1, KMAX_RES},
      '{K_MAX,          31'd2,          1'b1, SAT_RES},
      '{K_MAX,          K_MAX >> 1,     1'b1, SAT_RES},
      '{31'h5555_5555,  31'h2AAA_AAAA,  1'b1, SAT_RES},
      '{31'd10,         31'd3,          1'b0, NO_RES},
      '{31'd4,          31'd2,          1'b0, NO_RES},
      // largest central values that still fit, then the first that do not
      '{31'd33,         31'd16,         1'b0, NO_RES},
      '{31'd34,         31'd17,         1'b0, NO_RES},
      '{31'd35,         31'd17,         1'b0, NO_RES},
      '{31'd66,         31'd33,         1'b0, NO_RES},
      '{31'd67,         31'd34,         1'b0, NO_RES},
      // k choose 2 around the 32-bit boundary, one via the mirrored side
      '{31'd92682,      31'd2,          1'b0, NO_RES},
      '{31'd92683,      31'd2,          1'b0, NO_RES},
      '{31'd92683,      31'd92681,      1'b0, NO_RES}
   };

   binomial_coefficient_unit_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_total_items  (req_total_items),
      .req_chosen_items (req_chosen_items),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_coefficient  (rsp_coefficient),
      .rsp_overflow     (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // running value times (k - i), divided exactly by (i + 1), over the smaller side
   function automatic coef_result_type binomial_of(
         input logic [bcu_pkg::FIELD_W-1:0] total,
         input logic [bcu_pkg::FIELD_W-1:0] chosen);
      logic [63:0]     ceiling;
      logic [63:0]     running;
      logic [63:0]     passes;
      logic [63:0]     idx;
      coef_result_type res;
      ceiling = (64'd1 << bcu_pkg::RES_W) - 64'd1;
      res = '0;
      // more chosen than available: zero, no overflow
      if (chosen > total)
         return res;
      passes = (chosen < total - chosen) ? 64'(chosen) : 64'(total - chosen);
      running = 64'd1;
      // partial values only grow, so the first one past the ceiling settles it
      for (idx = 64'd0; idx < passes && !res.overflow; idx++) begin
         running = running * (64'(total) - idx) / (idx + 64'd1);
         if (running > ceiling)
            res.overflow = 1'b1;
      end
      res.coefficient = res.overflow ? bcu_pkg::SAT_VALUE
                                     : running[bcu_pkg::COEF_W-1:0];
      return res;
   endfunction

   // a share of small sets so the loop stays short, a share near the overflow edge,
   // and full-width values, most of which miss (n > k) or saturate within a pass or two
   task automatic random_pair(output logic [bcu_pkg::FIELD_W-1:0] total,
                              output logic [bcu_pkg::FIELD_W-1:0] chosen);
      int unsigned                 pick;
      logic [bcu_pkg::FIELD_W-1:0] offset;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         total  = bcu_pkg::FIELD_W'($urandom_range(0, 40));
         chosen = bcu_pkg::FIELD_W'($urandom_range(0, 32'(total) + 2));
      end else if (pick < 55) begin
         // huge set, tiny choice on either side
         total  = bcu_pkg::FIELD_W'($urandom);
         offset = bcu_pkg::FIELD_W'($urandom_range(0, 4));
         chosen = ($urandom_range(0, 1) == 0 || offset > total) ? offset
                                                                : total - offset;
      end else if (pick < 70) begin
         // central choice on a set of 28 .. 70, many passes, around the saturation point
         total  = bcu_pkg::FIELD_W'($urandom_range(28, 70));
         chosen = bcu_pkg::FIELD_W'($urandom_range(32'(total) / 2 - 3,
                                                   32'(total) / 2 + 3));
      end else if (pick < 85) begin
         total  = bcu_pkg::FIELD_W'($urandom);
         chosen = bcu_pkg::FIELD_W'($urandom);
      end else begin
         total  = bcu_pkg::FIELD_W'($urandom);
         chosen = bcu_pkg::FIELD_W'($urandom_range(0, 32'(total)));
      end
   endtask

   // offer one pair, hold it while stalled, log the expectation once the block is free
   task automatic offer_pair(input logic [bcu_pkg::FIELD_W-1:0] total,
                             input logic [bcu_pkg::FIELD_W-1:0] chosen,
                             input coef_result_type             want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_total_items  <= total;
      req_chosen_items <= chosen;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_coefs.push_back(want);
   endtask

   // sender goes quiet until every expected beat has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_coefs.size() != 0)
         @(posedge clock);
   endtask

   // stimulus
   initial begin : stimulus
      logic [bcu_pkg::FIELD_W-1:0] total;
      logic [bcu_pkg::FIELD_W-1:0] chosen;
      int                          phase;
      int                          count;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table, typed rows use their own value, the rest the predictor
      foreach (directed_rows[r])
         offer_pair(directed_rows[r].total, directed_rows[r].chosen,
                    directed_rows[r].typed ? directed_rows[r].want
                                           : binomial_of(directed_rows[r].total,
                                                         directed_rows[r].chosen));
      wait_for_results();

      // back-to-back burst against a long receiver hold, fills the block
      send_idle_pct = 0;
      hold_requests++;
      for (count = 0; count < BURST_PAIRS; count++) begin
         total  = bcu_pkg::FIELD_W'($urandom_range(0, 20));
         chosen = bcu_pkg::FIELD_W'($urandom_range(0, 20));
         offer_pair(total, chosen, binomial_of(total, chosen));
      end
      wait_for_results();

      // random pairs in three idle phases: slow receiver, slow sender, no idling
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 65 : 0;
         recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 15 : 0;
         for (count = 0; count < RANDOM_PAIRS / 3; count++) begin
            random_pair(total, chosen);
            offer_pair(total, chosen, binomial_of(total, chosen));
         end
      end
      wait_for_results();

      // idle tail to catch any beat nobody asked for
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // response side: check each accepted beat, then pick next cycle's stall
   initial begin : response_side
      int              hold_left;
      int              hold_served;
      coef_result_type want;
      hold_left   = 0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_coefs.size() == 0) begin
               $display("%0t: beat with nothing expected, coefficient %0d overflow %0b",
                        $time, rsp_coefficient, rsp_overflow);
               mismatch_count++;
            end else begin
               want = pending_coefs.pop_front();
               if (rsp_coefficient !== want.coefficient) begin
                  $display("%0t: coefficient mismatch, expected %0d, actual %0d",
                           $time, want.coefficient, rsp_coefficient);
                  mismatch_count++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $display("%0t: overflow mismatch, expected %0b, actual %0b",
                           $time, want.overflow, rsp_overflow);
                  mismatch_count++;
               end
            end
         end
         // long hold counted here, independent of the sender
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // watchdog: too long without a beat on either channel ends the run
   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/bcu_pkg.sv
hdl/bcu_ctrl.sv
hdl/bcu_dp.sv
hdl/binomial_coefficient_unit_top.sv
test/binomial_coefficient_unit_top_test.sv
